// ----- rtl/pngunf_pkg.sv -----
// Package for the PNG scanline unfilter: sizes, filter codes, register indexes
// and the metadata type carried between the accept stage and the compute stage.
// Depends on nothing; used by png_scanline_unfilter and its testbench.
`default_nettype none

package pngunf_pkg;

  // Widest scanline in pixels and the size of the row store in bytes.
  localparam int MAX_WIDTH = 4096;
  localparam int ROW_STORE = MAX_WIDTH * 4;

  // Widths that follow from the store size.
  localparam int ROW_ADDR_W = $clog2(ROW_STORE);
  localparam int ROW_LEN_W  = $clog2(ROW_STORE + 1);

  // Field and register widths.
  localparam int SAMPLE_W = 8;
  localparam int CHAN_W   = 2;
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [CHAN_W-1:0]     chan_t;
  typedef logic [ROW_ADDR_W-1:0] row_addr_t;
  typedef logic [ROW_LEN_W-1:0]  row_len_t;
  typedef logic [WIDTH_W-1:0]    width_t;
  typedef logic [HEIGHT_W-1:0]   height_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Filter type codes that change the data.
  localparam sample_t FILTER_SUB = 8'd1;
  localparam sample_t FILTER_UP  = 8'd2;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_HAS_ALPHA    = 2'd2;

  // Per-sample control handed from the accept stage to the compute stage.
  typedef struct packed {
    chan_t     channel;
    logic      use_sub;
    logic      use_up;
    logic      row_end;
    logic      image_end;
    row_addr_t addr;
  } sample_meta_t;

endpackage

`default_nettype wire

// ----- rtl/pngunf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module pngunf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/png_scanline_unfilter.sv -----
// Top level of the PNG scanline unfilter for 8-bit RGB and RGBA images.
// Depends on pngunf_pkg and pngunf_ram (the previous-row store).
`default_nettype none

// The block takes one byte of the inflated image stream per cycle and gives
// back one reconstructed sample per data byte; the first byte of each scanline
// is its filter type and yields no result. Sub and Up are undone, every other
// filter type passes bytes through. Throughput is one byte per cycle, held up
// only by out_ready. The accepting edge of a byte loads it into the compute
// register and starts the registered read of the previous-row RAM (16384 x 8,
// one write and one read port); the sum is stored in the output register once
// that register is free, which out_ready can delay.
// The row store needs no clearing pass after reset. Write the configuration
// registers only while no transaction is in flight; a new value takes effect
// on the next byte. image_width is clamped to 1..4096, and a height of zero
// counts as one.
module png_scanline_unfilter (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Configuration write port.
  input  wire logic                 cfg_wr_en,
  input  wire pngunf_pkg::cfg_idx_t  cfg_index,
  input  wire pngunf_pkg::cfg_data_t cfg_wr_data,
  // Input byte stream.
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pngunf_pkg::sample_t   in_data_byte,
  // Reconstructed samples.
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pngunf_pkg::sample_t        out_sample_value,
  output pngunf_pkg::chan_t          out_channel,
  output logic                      out_row_end,
  output logic                      out_image_end
);

  // Configuration registers.
  pngunf_pkg::width_t  image_width_r;
  pngunf_pkg::height_t image_height_r;
  logic                has_alpha_r;

  // Scan position state.
  pngunf_pkg::row_addr_t byte_in_row_r, byte_in_row_nxt;
  pngunf_pkg::height_t   row_index_r, row_index_nxt;
  pngunf_pkg::sample_t   row_filter_r, row_filter_nxt;
  logic                  expect_filter_r, expect_filter_nxt;
  // Byte position modulo three, the channel of an RGB byte.
  pngunf_pkg::chan_t     byte_mod3_r, byte_mod3_nxt;

  // Compute stage register.
  logic                     s1_valid_r;
  pngunf_pkg::sample_t      s1_data_r;
  pngunf_pkg::sample_meta_t s1_meta_r;
  pngunf_pkg::sample_meta_t meta_nxt;

  // Left pixel, one byte per channel.
  pngunf_pkg::sample_t left_pixel_r [4];

  // Output register.
  logic                out_valid_r;
  pngunf_pkg::sample_t out_sample_r;
  pngunf_pkg::chan_t   out_channel_r;
  logic                out_row_end_r;
  logic                out_image_end_r;

  logic                  in_fire;
  logic                  data_fire;
  logic                  s1_move;
  pngunf_pkg::width_t    width_clamped;
  pngunf_pkg::row_len_t  row_len;
  pngunf_pkg::height_t   rows_total;
  pngunf_pkg::chan_t     cur_chan;
  logic                  past_first_pixel;
  logic                  last_byte;
  logic                  last_row;
  pngunf_pkg::sample_t   up_byte;
  pngunf_pkg::sample_t   addend;
  pngunf_pkg::sample_t   sample_val;

  // Configuration writes; index three is unused.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= pngunf_pkg::WIDTH_W'(1);
      image_height_r <= pngunf_pkg::HEIGHT_W'(1);
      has_alpha_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pngunf_pkg::CFG_IMAGE_WIDTH: begin
          image_width_r <= cfg_wr_data[pngunf_pkg::WIDTH_W-1:0];
        end
        pngunf_pkg::CFG_IMAGE_HEIGHT: begin
          image_height_r <= cfg_wr_data[pngunf_pkg::HEIGHT_W-1:0];
        end
        pngunf_pkg::CFG_HAS_ALPHA: begin
          has_alpha_r <= cfg_wr_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshakes: the compute stage advances whenever the output register is free.
  assign s1_move   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_move;
  assign in_fire   = in_valid && in_ready;
  assign data_fire = in_fire && !expect_filter_r;

  // Row length in bytes and image height, with out-of-range values clamped.
  always_comb begin
    if (image_width_r == '0) begin
      width_clamped = pngunf_pkg::WIDTH_W'(1);
    end else if (image_width_r > pngunf_pkg::WIDTH_W'(pngunf_pkg::MAX_WIDTH)) begin
      width_clamped = pngunf_pkg::WIDTH_W'(pngunf_pkg::MAX_WIDTH);
    end else begin
      width_clamped = image_width_r;
    end
    if (has_alpha_r) begin
      row_len = {width_clamped, 2'b00};
    end else begin
      row_len = pngunf_pkg::ROW_LEN_W'({width_clamped, 1'b0})
              + pngunf_pkg::ROW_LEN_W'(width_clamped);
    end
    rows_total = (image_height_r == '0) ? pngunf_pkg::HEIGHT_W'(1) : image_height_r;
  end

  // Channel and first-pixel test follow the byte position, so a change of the
  // pixel format between transactions takes effect on the next byte.
  assign cur_chan         = has_alpha_r ? byte_in_row_r[1:0] : byte_mod3_r;
  assign past_first_pixel = has_alpha_r ? (byte_in_row_r >= pngunf_pkg::ROW_ADDR_W'(4))
                                        : (byte_in_row_r >= pngunf_pkg::ROW_ADDR_W'(3));

  // Position of the current byte within the row and the image.
  assign last_byte = ({1'b0, byte_in_row_r} + pngunf_pkg::ROW_LEN_W'(1)) >= row_len;
  assign last_row  = last_byte
                   && (({1'b0, row_index_r} + 17'd1) >= {1'b0, rows_total});

  // Metadata for the byte being accepted.
  always_comb begin
    meta_nxt.channel   = cur_chan;
    meta_nxt.use_sub   = (row_filter_r == pngunf_pkg::FILTER_SUB) && past_first_pixel;
    meta_nxt.use_up    = (row_filter_r == pngunf_pkg::FILTER_UP) && (row_index_r != '0);
    meta_nxt.row_end   = last_byte;
    meta_nxt.image_end = last_row;
    meta_nxt.addr      = byte_in_row_r;
  end

  // Next scan position after an accepted transaction.
  always_comb begin
    byte_in_row_nxt   = byte_in_row_r;
    row_index_nxt     = row_index_r;
    row_filter_nxt    = row_filter_r;
    expect_filter_nxt = expect_filter_r;
    byte_mod3_nxt     = byte_mod3_r;
    if (in_fire) begin
      if (expect_filter_r) begin
        row_filter_nxt    = in_data_byte;
        byte_in_row_nxt   = '0;
        byte_mod3_nxt     = '0;
        expect_filter_nxt = 1'b0;
      end else if (last_byte) begin
        byte_in_row_nxt   = '0;
        byte_mod3_nxt     = '0;
        expect_filter_nxt = 1'b1;
        row_index_nxt     = last_row ? '0 : row_index_r + pngunf_pkg::HEIGHT_W'(1);
      end else begin
        byte_in_row_nxt = byte_in_row_r + pngunf_pkg::ROW_ADDR_W'(1);
        if (byte_mod3_r == pngunf_pkg::CHAN_W'(2)) begin
          byte_mod3_nxt = '0;
        end else begin
          byte_mod3_nxt = byte_mod3_r + pngunf_pkg::CHAN_W'(1);
        end
      end
    end
  end

  // Scan position registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_row_r   <= '0;
      row_index_r     <= '0;
      row_filter_r    <= '0;
      expect_filter_r <= 1'b1;
      byte_mod3_r     <= '0;
    end else begin
      byte_in_row_r   <= byte_in_row_nxt;
      row_index_r     <= row_index_nxt;
      row_filter_r    <= row_filter_nxt;
      expect_filter_r <= expect_filter_nxt;
      byte_mod3_r     <= byte_mod3_nxt;
    end
  end

  // Compute stage register: loaded with each data byte, emptied into the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (data_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_fire) begin
      s1_data_r <= in_data_byte;
      s1_meta_r <= meta_nxt;
    end
  end

  // Previous-row store: read as the byte is accepted, written as it is finished.
  pngunf_ram #(
    .WIDTH (pngunf_pkg::SAMPLE_W),
    .DEPTH (pngunf_pkg::ROW_STORE)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (s1_valid_r && s1_move),
    .wr_addr (s1_meta_r.addr),
    .wr_data (sample_val),
    .rd_en   (data_fire),
    .rd_addr (byte_in_row_r),
    .rd_data (up_byte)
  );

  // Reconstruction: add the left neighbor or the byte above, modulo 256.
  always_comb begin
    if (s1_meta_r.use_sub) begin
      addend = left_pixel_r[s1_meta_r.channel];
    end else if (s1_meta_r.use_up) begin
      addend = up_byte;
    end else begin
      addend = '0;
    end
    sample_val = s1_data_r + addend;
  end

  // Left pixel store, updated with every finished sample.
  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_move) begin
      left_pixel_r[s1_meta_r.channel] <= sample_val;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_move) begin
      out_sample_r    <= sample_val;
      out_channel_r   <= s1_meta_r.channel;
      out_row_end_r   <= s1_meta_r.row_end;
      out_image_end_r <= s1_meta_r.image_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_sample_r;
  assign out_channel      = out_channel_r;
  assign out_row_end      = out_row_end_r;
  assign out_image_end    = out_image_end_r;

endmodule

`default_nettype wire

// ----- tb/tb_png_scanline_unfilter.sv -----
// Self-checking testbench for png_scanline_unfilter (Sub/Up scanline reconstruction).
// Holds a scoreboard class that predicts every reconstructed sample and checks it.
// Depends on pngunf_pkg and the png_scanline_unfilter RTL.
module tb_png_scanline_unfilter;
  timeunit 1ns;
  timeprecision 1ps;

  import pngunf_pkg::*;

  // Filter type that leaves the data unchanged.
  localparam sample_t FILTER_NONE = 8'd0;

  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // One reconstructed channel byte as it leaves the block.
  typedef struct packed {
    sample_t value;
    chan_t   channel;
    logic    row_end;
    logic    image_end;
  } recon_sample_t;

  // Receiver stall patterns.
  typedef enum int unsigned {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // Scoreboard: tracks the unfilter state, predicts samples and checks them in order.
  class unfilter_scoreboard;
    width_t        width_reg;
    height_t       height_reg;
    logic          alpha_reg;
    sample_t       row_above[ROW_STORE];
    sample_t       left_sample[4];
    int unsigned   byte_pos;
    int unsigned   row_num;
    sample_t       row_filter;
    bit            want_filter;
    recon_sample_t expected_samples[$];
    int unsigned   mismatches;
    int unsigned   bytes_noted;
    int unsigned   samples_checked;
    int unsigned   images_done;
    int unsigned   settings_done;

    function new();
      width_reg = 1;
      height_reg = 1;
      alpha_reg = 1'b0;
      byte_pos = 0;
      row_num = 0;
      row_filter = FILTER_NONE;
      want_filter = 1'b1;
      mismatches = 0;
      bytes_noted = 0;
      samples_checked = 0;
      images_done = 0;
      settings_done = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg = data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg = data[HEIGHT_W-1:0];
        CFG_HAS_ALPHA: begin
          alpha_reg = data[0];
          settings_done++;
        end
        default: ;
      endcase
    endfunction

    function int unsigned pixel_bytes();
      return alpha_reg ? 4 : 3;
    endfunction

    // Width is clamped to 1..MAX_WIDTH.
    function int unsigned row_length();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w * pixel_bytes();
    endfunction

    // A height of zero means one row.
    function int unsigned image_rows();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int unsigned pending();
      return expected_samples.size();
    endfunction

    // Called for every accepted input transaction.
    function void note_byte(sample_t b);
      int unsigned   bpp;
      int unsigned   ch;
      sample_t       v;
      recon_sample_t s;
      bpp = pixel_bytes();
      bytes_noted++;
      if (want_filter) begin
        row_filter = b;
        byte_pos = 0;
        want_filter = 1'b0;
        return;
      end
      ch = byte_pos % bpp;
      v = b;
      if (row_filter == FILTER_SUB && byte_pos >= bpp)
        v = b + left_sample[ch];
      else if (row_filter == FILTER_UP && row_num > 0)
        v = b + row_above[byte_pos];
      left_sample[ch] = v;
      row_above[byte_pos] = v;
      s.value = v;
      s.channel = chan_t'(ch);
      s.row_end = (byte_pos + 1 >= row_length());
      s.image_end = s.row_end && (row_num + 1 >= image_rows());
      expected_samples = {expected_samples, s};
      if (s.row_end) begin
        byte_pos = 0;
        want_filter = 1'b1;
        if (s.image_end) begin
          row_num = 0;
          images_done++;
        end else begin
          row_num = (row_num + 1) & 16'hFFFF;
        end
      end else begin
        byte_pos++;
      end
    endfunction

    // Called for every accepted output transaction.
    function void check_sample(sample_t value, chan_t channel, logic row_end, logic image_end);
      recon_sample_t want;
      samples_checked++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] sample with none expected: value=%02h ch=%0d row_end=%0b image_end=%0b",
                   $time, value, channel, row_end, image_end);
        return;
      end
      want = expected_samples.pop_front();
      if (value !== want.value || channel !== want.channel ||
          row_end !== want.row_end || image_end !== want.image_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] sample %0d mismatch", $time, samples_checked);
          $display("  expected value=%02h ch=%0d row_end=%0b image_end=%0b",
                   want.value, want.channel, want.row_end, want.image_end);
          $display("  actual   value=%02h ch=%0d row_end=%0b image_end=%0b",
                   value, channel, row_end, image_end);
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  cfg_idx_t  cfg_index = CFG_IMAGE_WIDTH;
  cfg_data_t cfg_wr_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sample_t   in_data_byte = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sample_t   out_sample_value;
  chan_t     out_channel;
  logic      out_row_end;
  logic      out_image_end;

  unfilter_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  rx_mode_t    rx_mode = RX_STEADY;
  int unsigned rx_left = 0;
  int unsigned rx_phase = 0;

  png_scanline_unfilter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_channel      (out_channel),
    .out_row_end      (out_row_end),
    .out_image_end    (out_image_end)
  );

  always #5 clk = ~clk;

  // Receiver: checks each output transaction and stalls on its own pattern.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready)
      sb.check_sample(out_sample_value, out_channel, out_row_end, out_image_end);
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_STEADY: out_ready <= 1'b1;
      RX_LIGHT:  out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:  out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= ((rx_phase % 7) < 3);
    endcase
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d samples outstanding", cycle_count, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  // Writes all three registers; only called while the block is idle.
  task automatic write_regs(input cfg_data_t width_data, input cfg_data_t height_data,
                            input cfg_data_t alpha_data);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wr_data <= width_data;
    @(posedge clk);
    sb.write_reg(CFG_IMAGE_WIDTH, width_data);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_wr_data <= height_data;
    @(posedge clk);
    sb.write_reg(CFG_IMAGE_HEIGHT, height_data);
    cfg_index <= CFG_HAS_ALPHA;
    cfg_wr_data <= alpha_data;
    @(posedge clk);
    sb.write_reg(CFG_HAS_ALPHA, alpha_data);
    cfg_wr_en <= 1'b0;
  endtask

  // Sends one byte as an input transaction; the sender works in bursts with gaps.
  task automatic send_byte(input sample_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
  endtask

  // Stops sending, waits for every outstanding sample, then lets the pipeline settle.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly Sub and Up, with pass-through and arbitrary filter codes mixed in.
  function automatic sample_t pick_filter();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return FILTER_SUB;
    if (r < 8) return FILTER_UP;
    if (r == 8) return FILTER_NONE;
    return sample_t'($urandom_range(0, 255));
  endfunction

  task automatic send_row(input sample_t filt);
    int unsigned len;
    send_byte(filt);
    len = sb.row_length();
    repeat (len) send_byte(sample_t'($urandom_range(0, 255)));
  endtask

  task automatic send_image();
    int unsigned rows;
    rows = sb.image_rows();
    repeat (rows) send_row(pick_filter());
  endtask

  // Stimulus sequence.
  initial begin
    int unsigned wsel;
    int unsigned w;
    int unsigned h;
    int unsigned a;
    int unsigned random_start;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one RGB pixel, pass-through filter, extreme sample values.
    send_byte(FILTER_NONE);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);
    wait_for_drain();

    // Width and height of zero count as one; RGBA with an unknown filter code.
    write_regs(16'd0, 16'd0, 16'd1);
    send_byte(8'hFF);
    send_byte(8'hFF); send_byte(8'h01); send_byte(8'h7F); send_byte(8'hFE);
    wait_for_drain();

    // Two-pixel RGB image: Sub with wrap on row 0, then Up with wrap on row 1.
    write_regs(16'd2, 16'd2, 16'd0);
    send_byte(FILTER_SUB);
    send_byte(8'hFF); send_byte(8'h10); send_byte(8'h20);
    send_byte(8'h01); send_byte(8'hF0); send_byte(8'hE0);
    send_byte(FILTER_UP);
    send_byte(8'h01); send_byte(8'h02); send_byte(8'h03);
    send_byte(8'h04); send_byte(8'h05); send_byte(8'h06);
    wait_for_drain();

    // Registers changed mid-image: the row shrinks and the image ends at the
    // next row end because the row count is already past the new height.
    write_regs(16'd4, 16'hFFFF, 16'd0);
    repeat (5) send_row(pick_filter());
    wait_for_drain();
    write_regs(16'd2, 16'd3, 16'd0);
    send_row(FILTER_UP);
    wait_for_drain();

    // Random images, mostly small, some back to back and some after a reconfiguration.
    random_start = sb.bytes_noted;
    while (sb.bytes_noted - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_for_drain();
        wsel = $urandom_range(0, 19);
        if (wsel == 0) w = 0;
        else if (wsel < 4) w = $urandom_range(9, 40);
        else w = $urandom_range(1, 8);
        h = $urandom_range(0, 5);
        a = $urandom_range(0, 1);
        // Bits above each register's width are don't-care.
        write_regs(cfg_data_t'(w | ($urandom_range(0, 7) << WIDTH_W)), cfg_data_t'(h),
                   cfg_data_t'(a | ($urandom_range(0, 1) << 1)));
      end
      send_image();
    end

    wait_for_drain();
    $display("Covered %0d stream bytes, %0d samples checked, %0d images, %0d register settings.",
             sb.bytes_noted, sb.samples_checked, sb.images_done, sb.settings_done);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d samples never arrived", sb.mismatches, sb.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- png_scanline_unfilter.f -----
rtl/pngunf_pkg.sv
rtl/pngunf_ram.sv
rtl/png_scanline_unfilter.sv
tb/tb_png_scanline_unfilter.sv
